[hw/rtl/scad_pkg.sv]
// ----------------------------------------------------------------------------
// Shift-add constant divider package
// Widths and defaults shared by the divider modules.
// ----------------------------------------------------------------------------
`default_nettype none

package scad_pkg;

    localparam int DIVISOR_W         = 14;
    localparam int DATA_WIDTH_DEF    = 32;
    localparam int POWER_TERMS_DEF   = 14;
    localparam int GROUP_SIZE        = 4;

endpackage : scad_pkg

`default_nettype wire

[hw/rtl/scad_recip.sv]
// ----------------------------------------------------------------------------
// Reciprocal pattern generator
// Holds the divisor and computes floor(2^(T-1) / divisor) with a restoring
// divider that retires one quotient bit per cycle after each divisor write.
// ----------------------------------------------------------------------------
`default_nettype none

module scad_recip #(
    parameter int MAX_POWER_TERMS = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [scad_pkg::DIVISOR_W-1:0] i_cfg_divisor,
    output logic                               o_busy,
    output logic [MAX_POWER_TERMS-1:0]         o_recip
);
    import scad_pkg::*;

    localparam int CNT_W = $clog2(MAX_POWER_TERMS);

    logic                       r_busy;
    logic [CNT_W-1:0]           r_cnt;
    logic [DIVISOR_W-1:0]       r_div;
    logic [DIVISOR_W:0]         r_rem;
    logic [MAX_POWER_TERMS-1:0] r_quot;
    logic [MAX_POWER_TERMS-1:0] r_recip;

    logic                       cfg_fire;
    logic                       shift_bit;
    logic [DIVISOR_W:0]         rem_sh;
    logic                       rem_ge;
    logic [DIVISOR_W:0]         n_rem;
    logic [MAX_POWER_TERMS-1:0] n_quot;
    logic                       last_step;

    assign cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign shift_bit = (r_cnt == '0);
    assign rem_sh    = {r_rem[DIVISOR_W-1:0], shift_bit};
    assign rem_ge    = (rem_sh >= {1'b0, r_div});
    assign n_rem     = rem_ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
    assign n_quot    = {r_quot[MAX_POWER_TERMS-2:0], rem_ge};
    assign last_step = (r_cnt == CNT_W'(MAX_POWER_TERMS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_recip <= {1'b1, {(MAX_POWER_TERMS-1){1'b0}}};
        end else if (cfg_fire) begin
            r_busy  <= 1'b1;
            r_cnt   <= '0;
        end else if (r_busy) begin
            r_cnt   <= r_cnt + 1'b1;
            if (last_step) begin
                r_busy  <= 1'b0;
                r_recip <= n_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cfg_fire) begin
            r_div  <= i_cfg_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_cfg_ready = !r_busy;
    assign o_busy      = r_busy;
    assign o_recip     = r_recip;

    a_cfg_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> (r_busy && (r_cnt == '0)))
        else $error("divisor write did not start the reciprocal pass");

    a_pass_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && last_step && !cfg_fire) |=> !r_busy)
        else $error("reciprocal pass overran its step count");

    a_busy_blocks_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_cfg_ready)
        else $error("divisor write accepted during reciprocal pass");

endmodule : scad_recip

`default_nettype wire

[hw/rtl/scad_datapath.sv]
// ----------------------------------------------------------------------------
// Shift-add datapath
// Input register, grouped partial sums of the shifted dividend terms, and a
// result register, each stage with its own valid bit and local backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module scad_datapath #(
    parameter int DATA_WIDTH      = 32,
    parameter int MAX_POWER_TERMS = 14
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_hold,
    input  wire logic [MAX_POWER_TERMS-1:0] i_recip,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [DATA_WIDTH-1:0]      i_dividend,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [DATA_WIDTH-1:0]           o_quotient_approx
);
    import scad_pkg::*;

    localparam int NUM_GROUPS = (MAX_POWER_TERMS + GROUP_SIZE - 1) / GROUP_SIZE;

    logic                       r_v1;
    logic [DATA_WIDTH-1:0]      r_x;
    logic [MAX_POWER_TERMS-1:0] r_mask;
    logic                       r_v2;
    logic [DATA_WIDTH-1:0]      r_part [NUM_GROUPS];
    logic                       r_v3;
    logic [DATA_WIDTH-1:0]      r_q;

    logic                       ld1;
    logic                       ld2;
    logic                       ld3;
    logic                       in_fire;
    logic [DATA_WIDTH-1:0]      term [NUM_GROUPS][GROUP_SIZE];
    logic [DATA_WIDTH-1:0]      n_part [NUM_GROUPS];
    logic [DATA_WIDTH-1:0]      n_q;

    assign ld3     = !r_v3 || i_ready;
    assign ld2     = !r_v2 || ld3;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1 && !i_hold;
    assign in_fire = i_valid && o_ready;

    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_term
            localparam int P = g * GROUP_SIZE + k;
            if (P < MAX_POWER_TERMS) begin : g_used
                assign term[g][k] = r_mask[MAX_POWER_TERMS-1-P] ? (r_x >> P) : '0;
            end else begin : g_unused
                assign term[g][k] = '0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_part[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                n_part[g] = n_part[g] + term[g][k];
            end
        end
    end

    always_comb begin
        n_q = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_q = n_q + r_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= in_fire;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x    <= i_dividend;
            r_mask <= i_recip;
        end
        if (ld2 && r_v1) begin
            r_part <= n_part;
        end
        if (ld3 && r_v2) begin
            r_q <= n_q;
        end
    end

    assign o_valid           = r_v3;
    assign o_quotient_approx = r_q;

    a_no_accept_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hold |-> !o_ready)
        else $error("dividend accepted during reciprocal pass");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !ld3) |=> (r_v2 && $stable(r_part[0])))
        else $error("partial sums lost while the result stage was stalled");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_quotient_approx)))
        else $error("quotient beat changed while waiting for the sink");

endmodule : scad_datapath

`default_nettype wire

[hw/rtl/shift_add_constant_divider_core.sv]
// ----------------------------------------------------------------------------
// Shift-add constant divider core
// Approximates dividend / divisor as the sum of dividend >> p over the set
// bits of floor(2^(T-1) / divisor), with T reciprocal terms.
//
//   Channel   Direction  Handshake                  Payload
//   cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_divisor
//   in        in         i_valid / o_ready          i_dividend
//   out       out        o_valid / i_ready          o_quotient_approx
//
// One beat is taken per cycle unless the pipeline stalls or a divisor write
// runs; each result passes through input, partial-sum and result registers.
// A divisor write runs the restoring divider, and while it runs neither
// the cfg nor the in channel accepts a beat.
// Reset loads the reciprocal pattern 2^(T-1), which is that of divisor one.
// Every pipeline stage stalls on its own, so a waiting result does not block
// new beats while earlier stages are empty.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_add_constant_divider_core #(
    parameter int DATA_WIDTH      = scad_pkg::DATA_WIDTH_DEF,
    parameter int MAX_POWER_TERMS = scad_pkg::POWER_TERMS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [scad_pkg::DIVISOR_W-1:0] i_cfg_divisor,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [DATA_WIDTH-1:0]          i_dividend,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [DATA_WIDTH-1:0]               o_quotient_approx
);
    import scad_pkg::*;

    logic                       recip_busy;
    logic [MAX_POWER_TERMS-1:0] recip;

    scad_recip #(
        .MAX_POWER_TERMS (MAX_POWER_TERMS)
    ) u_recip (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_divisor (i_cfg_divisor),
        .o_busy        (recip_busy),
        .o_recip       (recip)
    );

    scad_datapath #(
        .DATA_WIDTH      (DATA_WIDTH),
        .MAX_POWER_TERMS (MAX_POWER_TERMS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_hold            (recip_busy),
        .i_recip           (recip),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_dividend        (i_dividend),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_quotient_approx (o_quotient_approx)
    );

endmodule : shift_add_constant_divider_core

`default_nettype wire
